### design/vertex_dedup_index_builder_assert.svh
// Assertion macros shared by the vertex deduplication RTL.
`ifndef VERTEX_DEDUP_INDEX_BUILDER_ASSERT_SVH
`define VERTEX_DEDUP_INDEX_BUILDER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VDIB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define VDIB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/vdib_pkg.sv
// Package with constants, types and codes for the vertex deduplication block.
`default_nettype none
package vdib_pkg;

  // Table size must be a power of two; the probe wraps by overflow of the slot.
  localparam int TABLE_SLOTS  = 4096;
  localparam int MAX_VERTICES = 2048;
  localparam int WORDS        = 8;
  localparam int KEYS         = 4;

  localparam int SLOT_W    = $clog2(TABLE_SLOTS);
  localparam int KEY_AW    = SLOT_W + $clog2(KEYS);
  localparam int IDX_W     = $clog2(MAX_VERTICES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int WORD_W    = 32;
  localparam int KEY_W     = 2 * WORD_W;
  localparam int OUT_IDX_W = 11;
  localparam int META_W    = IDX_W + 1;

  localparam logic [WORD_W-1:0] MIX_MULT  = 32'h9e37_79b9;
  localparam int                MIX_SHIFT = 3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HASH,
    ST_HASH_END,
    ST_OCC_RD,
    ST_OCC_CK,
    ST_KEY_RD,
    ST_KEY_CK,
    ST_WRITE,
    ST_META_WR,
    ST_RESULT
  } vdib_state_e;

  typedef struct packed {
    logic capture;
    logic hash_step;
    logic load_slot;
    logic clr_step;
    logic meta_rd;
    logic key_rd;
    logic key_wr;
    logic meta_wr;
    logic k_clr;
    logic k_inc;
    logic next_slot;
    logic set_hit;
    logic set_new;
    logic set_full;
    logic res_load;
  } vdib_cmd_t;

  typedef struct packed {
    logic hash_last;
    logic clr_last;
    logic occ;
    logic room;
    logic key_eq;
    logic k_last;
    logic probe_last;
    logic out_free;
  } vdib_sts_t;

endpackage
`default_nettype wire

### design/vdib_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module vdib_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### design/vdib_ctrl.sv
// Controller state machine of the vertex deduplication block.
`default_nettype none
module vdib_ctrl
  import vdib_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      start_of_mesh_i,
  output logic           in_ready_o,
  output vdib_cmd_t      cmd_o,
  input  wire vdib_sts_t sts_i
);

  vdib_state_e state_q, state_d;
  logic        item_q, item_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      item_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      item_q  <= item_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          item_d        = 1'b1;
          state_d       = start_of_mesh_i ? ST_CLEAR : ST_HASH;
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = item_q ? ST_HASH : ST_IDLE;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_last) begin
          state_d = ST_HASH_END;
        end
      end
      ST_HASH_END: begin
        cmd_o.load_slot = 1'b1;
        state_d         = ST_OCC_RD;
      end
      ST_OCC_RD: begin
        cmd_o.meta_rd = 1'b1;
        cmd_o.k_clr   = 1'b1;
        state_d       = ST_OCC_CK;
      end
      ST_OCC_CK: begin
        if (!sts_i.occ) begin
          if (sts_i.room) begin
            state_d = ST_WRITE;
          end else begin
            cmd_o.set_full = 1'b1;
            state_d        = ST_RESULT;
          end
        end else begin
          cmd_o.key_rd = 1'b1;
          state_d      = ST_KEY_CK;
        end
      end
      ST_KEY_RD: begin
        cmd_o.key_rd = 1'b1;
        state_d      = ST_KEY_CK;
      end
      ST_KEY_CK: begin
        if (!sts_i.key_eq) begin
          if (sts_i.probe_last) begin
            cmd_o.set_full = 1'b1;
            state_d        = ST_RESULT;
          end else begin
            cmd_o.next_slot = 1'b1;
            state_d         = ST_OCC_RD;
          end
        end else if (sts_i.k_last) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_RESULT;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_KEY_RD;
        end
      end
      ST_WRITE: begin
        cmd_o.key_wr = 1'b1;
        if (sts_i.k_last) begin
          state_d = ST_META_WR;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      ST_META_WR: begin
        cmd_o.meta_wr = 1'b1;
        cmd_o.set_new = 1'b1;
        state_d       = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          item_d         = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/vdib_dp.sv
// Datapath of the vertex deduplication block: hash, slot tables and result register.
`default_nettype none
module vdib_dp
  import vdib_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [WORDS*WORD_W-1:0]  words_i,
  input  wire vdib_cmd_t                cmd_i,
  output vdib_sts_t                     sts_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic      [OUT_IDX_W-1:0]     out_index_o,
  output logic                          out_is_new_o,
  output logic                          out_full_o
);

  logic [WORDS*WORD_W-1:0] words_q;
  logic [2:0]              w_q;
  logic [WORD_W-1:0]       prod_q, wd_q, hash_q, hash_d;
  logic                    mix_v_q;
  logic [SLOT_W-1:0]       slot_q, probe_q;
  logic [1:0]              k_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [IDX_W-1:0]        res_idx_q;
  logic                    res_new_q, res_full_q;
  logic                    out_valid_q, out_new_q, out_full_q;
  logic [OUT_IDX_W-1:0]    out_idx_q;
  logic [31:0]             idx_wide;
  logic [KEY_W-1:0]        key_word, key_rdata;
  logic [META_W-1:0]       meta_wdata, meta_rdata;

  assign key_word = words_q[KEY_W*k_q +: KEY_W];
  assign hash_d   = mix_v_q ? (hash_q ^ (wd_q + (prod_q >> MIX_SHIFT))) : hash_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      words_q <= words_i;
      hash_q  <= '0;
    end else begin
      hash_q <= hash_d;
    end
    if (cmd_i.hash_step) begin
      prod_q <= MIX_MULT * words_q[WORD_W*w_q +: WORD_W];
      wd_q   <= words_q[WORD_W*w_q +: WORD_W];
    end
    if (cmd_i.set_hit) begin
      res_idx_q  <= meta_rdata[IDX_W-1:0];
      res_new_q  <= 1'b0;
      res_full_q <= 1'b0;
    end else if (cmd_i.set_new) begin
      res_idx_q  <= cnt_q[IDX_W-1:0];
      res_new_q  <= 1'b1;
      res_full_q <= 1'b0;
    end else if (cmd_i.set_full) begin
      res_idx_q  <= '0;
      res_new_q  <= 1'b0;
      res_full_q <= 1'b1;
    end
    if (cmd_i.res_load) begin
      out_idx_q  <= idx_wide[OUT_IDX_W-1:0];
      out_new_q  <= res_new_q;
      out_full_q <= res_full_q;
    end
  end

  assign idx_wide = 32'(res_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= '0;
      mix_v_q     <= 1'b0;
      slot_q      <= '0;
      probe_q     <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mix_v_q <= cmd_i.hash_step;
      if (cmd_i.capture) begin
        w_q    <= '0;
        slot_q <= '0;
      end else if (cmd_i.hash_step) begin
        w_q <= w_q + 3'd1;
      end
      if (cmd_i.clr_step) begin
        slot_q <= slot_q + 1'b1;
        cnt_q  <= '0;
      end else if (cmd_i.load_slot) begin
        slot_q  <= hash_d[SLOT_W-1:0];
        probe_q <= '0;
      end else if (cmd_i.next_slot) begin
        slot_q  <= slot_q + 1'b1;
        probe_q <= probe_q + 1'b1;
      end
      if (cmd_i.meta_wr) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.k_clr) begin
        k_q <= '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 2'd1;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign meta_wdata = cmd_i.meta_wr ? {1'b1, cnt_q[IDX_W-1:0]} : '0;

  vdib_ram #(
    .WIDTH(META_W),
    .DEPTH(TABLE_SLOTS)
  ) u_meta_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.clr_step | cmd_i.meta_wr),
    .waddr_i(slot_q),
    .wdata_i(meta_wdata),
    .re_i   (cmd_i.meta_rd),
    .raddr_i(slot_q),
    .rdata_o(meta_rdata)
  );

  vdib_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_SLOTS * KEYS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.key_wr),
    .waddr_i({slot_q, k_q}),
    .wdata_i(key_word),
    .re_i   (cmd_i.key_rd),
    .raddr_i({slot_q, k_q}),
    .rdata_o(key_rdata)
  );

  assign sts_o.hash_last  = (w_q == 3'(WORDS - 1));
  assign sts_o.clr_last   = (slot_q == {SLOT_W{1'b1}});
  assign sts_o.occ        = meta_rdata[IDX_W];
  assign sts_o.room       = (cnt_q < CNT_W'(MAX_VERTICES));
  assign sts_o.key_eq     = (key_rdata == key_word);
  assign sts_o.k_last     = (k_q == 2'(KEYS - 1));
  assign sts_o.probe_last = (probe_q == {SLOT_W{1'b1}});
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_index_o  = out_idx_q;
  assign out_is_new_o = out_new_q;
  assign out_full_o   = out_full_q;

endmodule
`default_nettype wire

### design/vertex_dedup_index_builder.sv
// Top level of the vertex deduplication index builder.
// This block takes one vertex word (eight raw float words plus a start-of-mesh flag in
// tuser) and returns one result word with the vertex's index in the unique vertex list,
// an is_new flag when the vertex was stored just now, and a table_full flag when a new
// vertex found no room (the index then reads 0). The hash of each vertex goes through a
// single shared 32-bit multiplier, one input word per cycle: eight multiplies and one
// more step to fold in the last mix. The lookup probes the slot table linearly: each
// slot visited is read for its occupancy and index, then its 64-bit key words are read
// and compared one after another. Storing a new vertex adds the key word writes and then
// the index write to the single-port-write memories. The result is then handed to the
// output register once it is free, before the next word is taken. After reset, and for
// every word with start_of_mesh set, a clearing pass sweeps the whole occupancy memory,
// one slot per cycle, while no word is taken. The output register lets a new word be
// taken while the previous result still waits.
`default_nettype none
module vertex_dedup_index_builder
  import vdib_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v from the lowest bit up.
  input  wire logic [255:0] s_axis_tdata,
  // start_of_mesh.
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // vertex_index, then zero fill.
  output logic      [15:0]  m_axis_tdata,
  // is_new, table_full from the lowest bit up.
  output logic      [1:0]   m_axis_tuser
);

  vdib_cmd_t            cmd;
  vdib_sts_t            sts;
  logic [OUT_IDX_W-1:0] out_index;
  logic                 out_is_new, out_full;

  // The controller sequences hashing, clearing, probing and insertion.
  vdib_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .start_of_mesh_i(s_axis_tuser[0]),
    .in_ready_o     (s_axis_tready),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  // The datapath holds the vertex, the hash, both slot memories and the result.
  vdib_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .words_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_index_o (out_index),
    .out_is_new_o(out_is_new),
    .out_full_o  (out_full)
  );

  assign m_axis_tdata = {{(16 - OUT_IDX_W){1'b0}}, out_index};
  assign m_axis_tuser = {out_full, out_is_new};

`include "vertex_dedup_index_builder_assert.svh"

  // A result is never both new and a full-table refusal, and a refusal carries index 0.
  `VDIB_ASSERT_IMPL(a_new_not_full, m_axis_tvalid, !(out_is_new && out_full))
  `VDIB_ASSERT_IMPL(a_full_zero_index, m_axis_tvalid && out_full, out_index == '0)
  // Once a word is taken, the block is busy with it on the next cycle.
  `VDIB_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // A result is loaded only when the output register is free.
  `VDIB_ASSERT_IMPL(a_load_when_free, cmd.res_load, !m_axis_tvalid || m_axis_tready)

endmodule
`default_nettype wire
